>>> sv/bmc_pkg.sv
// Shared types, codes and reset values of the boat mode controller.
// No dependencies; used by bmc_step and boat_mode_controller.
`timescale 1ns / 1ps

package bmc_pkg;

  // Mode codes as they appear in the result item
  localparam logic [2:0] MODE_CODE_MANUAL   = 3'd0;
  localparam logic [2:0] MODE_CODE_STOP     = 3'd1;
  localparam logic [2:0] MODE_CODE_EXTERNAL = 3'd2;
  localparam logic [2:0] MODE_CODE_SENS     = 3'd3;
  localparam logic [2:0] MODE_CODE_QUIT     = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_STOP_LED_OFF = 3'd0;
  localparam logic [2:0] REG_STOP_LED_ON  = 3'd1;
  localparam logic [2:0] REG_QUIT_WAIT    = 3'd2;
  localparam logic [2:0] REG_LONG_PRESS   = 3'd3;
  localparam logic [2:0] REG_MAN_OFF      = 3'd4;
  localparam logic [2:0] REG_MAN_ON       = 3'd5;
  localparam logic [2:0] REG_SENS_OFF     = 3'd6;
  localparam logic [2:0] REG_SENS_ON      = 3'd7;

  localparam int unsigned PERIOD_W = 17;
  localparam int unsigned PRESS_W  = 20;
  localparam int unsigned BLINK_W  = 8;
  localparam int unsigned SENS_W   = 5;
  localparam int unsigned EVAL_W   = 8;
  localparam int unsigned IN_W     = 24;
  localparam int unsigned OUT_W    = 16;
  localparam int unsigned CFG_W    = 20;

  localparam logic [PRESS_W-1:0]  PRESS_MAX    = '1;
  localparam logic [EVAL_W-1:0]   EVAL_MAX     = '1;
  localparam logic [SENS_W-1:0]   SENS_MAX     = 5'd20;
  localparam logic [SENS_W-1:0]   SENS_RESET   = 5'd5;
  localparam logic signed [7:0]   STICK_UP     = 8'sd20;
  localparam logic signed [7:0]   STICK_DOWN   = -8'sd20;

  typedef enum logic [4:0] {
    MODE_MANUAL   = 5'b00001,
    MODE_STOP     = 5'b00010,
    MODE_EXTERNAL = 5'b00100,
    MODE_SENS     = 5'b01000,
    MODE_QUIT     = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] stop_led_off;
    logic [PERIOD_W-1:0] stop_led_on;
    logic [PERIOD_W-1:0] quit_wait;
    logic [PRESS_W-1:0]  long_press;
    logic [BLINK_W-1:0]  man_off;
    logic [BLINK_W-1:0]  man_on;
    logic [BLINK_W-1:0]  sens_off;
    logic [BLINK_W-1:0]  sens_on;
  } cfg_t;

  typedef struct packed {
    mode_t               mode;
    logic                led;
    logic [PERIOD_W-1:0] countdown;
    logic [PRESS_W-1:0]  press_count;
    logic                press_timing;
    logic [EVAL_W-1:0]   eval_count;
    logic [SENS_W-1:0]   threshold;
    logic                top_pending;
    logic                bottom_pending;
    logic                stick_pending;
  } state_t;

  typedef struct packed {
    logic [3:0]        timer_ticks;
    logic signed [7:0] stick_y;
    logic              stick_off_centre;
    logic              stick_moved;
    logic              bottom_pressed;
    logic              bottom_changed;
    logic              top_pressed;
    logic              top_changed;
  } in_item_t;

  typedef struct packed {
    logic              mode_changed;
    logic [SENS_W-1:0] sensitivity;
    logic              evaluate_motors;
    logic              stop_motors;
    logic              led_on;
    logic [2:0]        mode;
  } res_item_t;

  localparam cfg_t CFG_RESET = '{
    stop_led_off: 17'd70000,
    stop_led_on:  17'd6000,
    quit_wait:    17'd50000,
    long_press:   20'd60000,
    man_off:      8'd16,
    man_on:       8'd4,
    sens_off:     8'd4,
    sens_on:      8'd16
  };

  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] c;
    case (m)
      MODE_MANUAL:   c = MODE_CODE_MANUAL;
      MODE_STOP:     c = MODE_CODE_STOP;
      MODE_EXTERNAL: c = MODE_CODE_EXTERNAL;
      MODE_SENS:     c = MODE_CODE_SENS;
      MODE_QUIT:     c = MODE_CODE_QUIT;
      default:       c = MODE_CODE_STOP;
    endcase
    return c;
  endfunction

endpackage

>>> sv/boat_mode_controller.sv
// Top level of the boat mode controller: stream ports, configuration
// registers, input and result registers. Depends on bmc_pkg and bmc_step.
`timescale 1ns / 1ps
//
//  channel  | ports                           | carries
//  ---------+---------------------------------+------------------------------
//  in       | in_tvalid in_tready in_tdata    | one control loop pass (item)
//  out      | out_tvalid out_tready out_tdata | one result item per pass
//  cfg      | cfg_valid cfg_ready cfg_index   | register write, always taken
//           | cfg_data                        |
//
//  One item is accepted per cycle while in_tready is high; its result passes
//  from the input register through one pass of bmc_step to the result register.
//  The controller state advances when the item leaves the input register.
//  Synchronous active-low reset restores state, configuration and valid flags
//  to defaults. A stalled result register holds the next item in the input
//  register and drops in_tready only while both are full.

module boat_mode_controller import bmc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // [0] top_changed, [1] top_pressed, [2] bottom_changed, [3] bottom_pressed,
  // [4] stick_moved, [5] stick_off_centre, [13:6] stick_y, [17:14] timer_ticks
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // [2:0] mode, [3] led_on, [4] stop_motors, [5] evaluate_motors,
  // [10:6] sensitivity, [11] mode_changed
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int unsigned IN_USED  = $bits(in_item_t);
  localparam int unsigned OUT_USED = $bits(res_item_t);

  cfg_t      cfg_r, cfg_nxt;
  state_t    state_r, state_nxt;
  in_item_t  in_r;
  logic      in_v_r;
  res_item_t res_r, res_nxt;
  logic      out_v_r;
  logic      advance;

  // Move the held item through the step when the result slot is free
  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_W-OUT_USED){1'b0}}, res_r};

  bmc_step u_step (
    .cur  (state_r),
    .cfg  (cfg_r),
    .item (in_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  // Register writes land in the field named by the index
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_STOP_LED_OFF: cfg_nxt.stop_led_off = cfg_data[PERIOD_W-1:0];
        REG_STOP_LED_ON:  cfg_nxt.stop_led_on  = cfg_data[PERIOD_W-1:0];
        REG_QUIT_WAIT:    cfg_nxt.quit_wait    = cfg_data[PERIOD_W-1:0];
        REG_LONG_PRESS:   cfg_nxt.long_press   = cfg_data[PRESS_W-1:0];
        REG_MAN_OFF:      cfg_nxt.man_off      = cfg_data[BLINK_W-1:0];
        REG_MAN_ON:       cfg_nxt.man_on       = cfg_data[BLINK_W-1:0];
        REG_SENS_OFF:     cfg_nxt.sens_off     = cfg_data[BLINK_W-1:0];
        REG_SENS_ON:      cfg_nxt.sens_on      = cfg_data[BLINK_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
      state_r.mode           <= MODE_STOP;
      state_r.led            <= 1'b1;
      state_r.countdown      <= '0;
      state_r.press_count    <= '0;
      state_r.press_timing   <= 1'b0;
      state_r.eval_count     <= '0;
      state_r.threshold      <= SENS_RESET;
      state_r.top_pending    <= 1'b0;
      state_r.bottom_pending <= 1'b0;
      state_r.stick_pending  <= 1'b0;
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
      if (advance) state_r <= state_nxt;
      // hold the input register until its item has passed the step
      if (in_tvalid && in_tready) in_v_r <= 1'b1;
      else if (advance)           in_v_r <= 1'b0;
      if (advance)         out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) in_r <= in_tdata[IN_USED-1:0];
    if (advance) res_r <= res_nxt;
  end

  // Threshold stays inside its range
  a_sens_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.threshold <= SENS_MAX)
    else $error("sensitivity threshold above its limit");

  // Motor evaluation only comes out of manual mode without a stop jump
  a_eval_manual: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.evaluate_motors |->
      res_r.mode == MODE_CODE_MANUAL && !res_r.stop_motors)
    else $error("evaluate strobe outside manual mode");

  // Controller state moves only with an item
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !advance |=> $stable(state_r))
    else $error("state changed without an item");

  // Mode-changed flag matches the stored mode before and after the pass
  a_mode_flag: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && advance |=>
      res_r.mode_changed == (state_r.mode != $past(state_r.mode)))
    else $error("mode_changed disagrees with mode update");

  // Result register gets a new item only when its previous one is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready |-> !advance)
    else $error("result overwritten while stalled");

endmodule

>>> sv/bmc_step.sv
// One control loop pass: next controller state and result item from the
// current state, configuration and input item. Depends on bmc_pkg.
`timescale 1ns / 1ps

module bmc_step import bmc_pkg::*; (
  input  state_t    cur,
  input  cfg_t      cfg,
  input  in_item_t  item,
  output state_t    nxt,
  output res_item_t res
);

  // Time the bottom press: restart on a fresh press, else count held passes
  function automatic state_t press_tick(state_t s, logic pr);
    state_t r;
    r = s;
    if (s.bottom_pending && pr) begin
      r.press_count    = '0;
      r.press_timing   = 1'b1;
      r.bottom_pending = 1'b0;
    end else if (pr && s.press_count < PRESS_MAX) begin
      r.press_count = s.press_count + 1'b1;
    end
    return r;
  endfunction

  function automatic state_t enter_quit(state_t s, logic [PERIOD_W-1:0] wait_len);
    state_t r;
    r = s;
    r.mode           = MODE_QUIT;
    r.press_count    = '0;
    r.press_timing   = 1'b0;
    r.countdown      = wait_len;
    r.led            = 1'b0;
    r.bottom_pending = 1'b0;
    r.stick_pending  = 1'b0;
    return r;
  endfunction

  function automatic state_t blink(state_t s, logic [PERIOD_W-1:0] off_len,
                                   logic [PERIOD_W-1:0] on_len);
    state_t r;
    r = s;
    if (s.led) begin
      r.led       = 1'b0;
      r.countdown = off_len;
    end else begin
      r.led       = 1'b1;
      r.countdown = on_len;
    end
    return r;
  endfunction

  function automatic logic long_hit(state_t s, logic [PRESS_W-1:0] lim, logic pr);
    return (s.press_count >= lim) && s.press_timing && pr;
  endfunction

  always_comb begin
    state_t     s;
    logic       stop_out;
    logic       eval_out;
    logic [8:0] tick_sum;
    logic       eval_due;

    s        = cur;
    stop_out = 1'b0;
    eval_out = 1'b0;

    s.top_pending    = s.top_pending | item.top_changed;
    s.bottom_pending = s.bottom_pending | item.bottom_changed;
    s.stick_pending  = s.stick_pending | item.stick_moved;
    tick_sum         = {1'b0, s.eval_count} + {5'd0, item.timer_ticks};
    s.eval_count     = tick_sum[8] ? EVAL_MAX : tick_sum[7:0];
    eval_due         = s.eval_count > {3'd0, s.threshold};

    // Top press stops from any mode
    if (s.top_pending && item.top_pressed) begin
      s.mode          = MODE_STOP;
      s.countdown     = '0;
      s.top_pending   = 1'b0;
      s.stick_pending = 1'b0;
      stop_out        = 1'b1;
    end

    case (s.mode)
      MODE_STOP: begin
        if (s.stick_pending) begin
          s.mode           = MODE_MANUAL;
          s.countdown      = '0;
          s.press_timing   = 1'b0;
          s.press_count    = '0;
          s.bottom_pending = 1'b0;
          s.eval_count     = '0;
        end else begin
          if (s.countdown == '0) s = blink(s, cfg.stop_led_off, cfg.stop_led_on);
          else s.countdown = s.countdown - 1'b1;
          s = press_tick(s, item.bottom_pressed);
          if (long_hit(s, cfg.long_press, item.bottom_pressed)) begin
            s = enter_quit(s, cfg.quit_wait);
          end
        end
      end
      MODE_MANUAL: begin
        s = press_tick(s, item.bottom_pressed);
        if (s.press_count < cfg.long_press && s.bottom_pending && s.press_timing &&
            !item.bottom_pressed) begin
          // short press released: hand over to external control
          s.mode           = MODE_EXTERNAL;
          s.press_count    = '0;
          s.press_timing   = 1'b0;
          s.bottom_pending = 1'b0;
          s.stick_pending  = 1'b0;
        end else if (long_hit(s, cfg.long_press, item.bottom_pressed)) begin
          s = enter_quit(s, cfg.quit_wait);
        end else if (eval_due) begin
          s.eval_count = '0;
          if (s.countdown <= {{(PERIOD_W-1){1'b0}}, 1'b1}) begin
            s = blink(s, {9'd0, cfg.man_off}, {9'd0, cfg.man_on});
          end else begin
            s.countdown = s.countdown - 1'b1;
          end
          eval_out = item.stick_off_centre;
        end
      end
      MODE_EXTERNAL: begin
        s.led = 1'b1;
        if (s.stick_pending) begin
          s.mode         = MODE_MANUAL;
          s.press_timing = 1'b0;
          s.press_count  = '0;
          s.eval_count   = '0;
          s.countdown    = '0;
          s.led          = 1'b0;
        end
      end
      MODE_SENS: begin
        if (s.bottom_pending && item.bottom_pressed) begin
          s.bottom_pending = 1'b0;
          s.press_count    = '0;
          s.press_timing   = 1'b0;
          s.mode           = MODE_MANUAL;
          s.led            = 1'b0;
          s.countdown      = '0;
        end else begin
          if (eval_due) begin
            s.eval_count = '0;
            if (s.countdown == '0) begin
              s = blink(s, {9'd0, cfg.sens_off}, {9'd0, cfg.sens_on});
            end else begin
              s.countdown = s.countdown - 1'b1;
            end
          end
          if (s.stick_pending) begin
            s.stick_pending = 1'b0;
            if (item.stick_y > STICK_UP) begin
              if (s.threshold < SENS_MAX) s.threshold = s.threshold + 1'b1;
            end else if (item.stick_y < STICK_DOWN) begin
              if (s.threshold != '0) s.threshold = s.threshold - 1'b1;
            end
          end
        end
      end
      MODE_QUIT: begin
        if (s.countdown == '0) begin
          s.mode           = MODE_SENS;
          s.stick_pending  = 1'b0;
          s.bottom_pending = 1'b0;
        end else begin
          s.countdown = s.countdown - 1'b1;
          if (s.stick_pending) begin
            s.mode      = MODE_MANUAL;
            s.led       = 1'b0;
            s.countdown = '0;
          end
        end
      end
      default: begin
      end
    endcase

    nxt                 = s;
    res.mode            = mode_code(s.mode);
    res.led_on          = s.led;
    res.stop_motors     = stop_out;
    res.evaluate_motors = eval_out;
    res.sensitivity     = s.threshold;
    res.mode_changed    = (s.mode != cur.mode);
  end

endmodule
